// ===== rtl/scw_pkg.sv =====
// ----------------------------------------------------------------------------
// scw_pkg: shared types and constants of the serpentine coverage waypoint core
// Holds the item codes, the request and result records, the back-end states
// and the divider step count.
// ----------------------------------------------------------------------------
package scw_pkg;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_NEXT = 1'b1
  } op_e;

  // Request handed from the front end to the back end.
  typedef struct packed {
    logic        op;
    logic [31:0] width_span;
    logic [31:0] height_span;
  } cmd_t;

  // One waypoint as it leaves the block.
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [10:0]        row_number;
    logic [10:0]        step_number;
    logic               final_point;
    logic               point_valid;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV_W,
    BK_DIV_H,
    BK_EMIT
  } bk_state_t;

  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

endpackage

// ===== rtl/scw_fifo.sv =====
// ----------------------------------------------------------------------------
// scw_fifo: small register queue
// Power-of-two depth, first word fall-through read, full and empty flags.
// ----------------------------------------------------------------------------
module scw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/scw_front.sv =====
// ----------------------------------------------------------------------------
// scw_front: request intake
// Take an item, form the absolute spans of a load and queue the request.
// ----------------------------------------------------------------------------
module scw_front (
  input  logic               push,
  output logic               full,
  input  logic               op,
  input  logic signed [31:0] upper_left_x,
  input  logic signed [31:0] upper_left_y,
  input  logic signed [31:0] upper_right_x,
  input  logic signed [31:0] lower_left_y,
  output logic               q_push,
  output scw_pkg::cmd_t      q_data,
  input  logic               q_full
);

  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic        [32:0] ax;
  logic        [32:0] ay;

  // 33-bit differences never overflow; the magnitude fits in 32 bits.
  assign dx = {upper_left_x[31], upper_left_x} - {upper_right_x[31], upper_right_x};
  assign dy = {upper_left_y[31], upper_left_y} - {lower_left_y[31], lower_left_y};
  assign ax = dx[32] ? 33'(-dx) : 33'(dx);
  assign ay = dy[32] ? 33'(-dy) : 33'(dy);

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_data.op          = op;
    q_data.width_span  = ax[31:0];
    q_data.height_span = ay[31:0];
  end

endmodule

// ===== rtl/scw_div.sv =====
// ----------------------------------------------------------------------------
// scw_div: cell count divider
// Restoring division of a 32-bit span by the diameter, one bit a cycle,
// quotient saturated at MAX_CELLS-1 (a zero divisor saturates too).
// ----------------------------------------------------------------------------
module scw_div #(
  parameter int MAX_CELLS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [31:0]                  dividend,
  input  logic [23:0]                  divisor,
  output logic                         done,
  output logic [$clog2(MAX_CELLS)-1:0] quotient
);

  localparam int          LW    = $clog2(MAX_CELLS);
  localparam logic [31:0] MAX_Q = 32'(MAX_CELLS - 1);

  logic [23:0]                     dvs;
  logic [23:0]                     rem;
  logic [31:0]                     quo;
  logic [scw_pkg::DIV_CNT_W-1:0]   cnt;
  logic                            busy;
  logic [24:0]                     trial;
  logic                            take;

  assign trial = {rem, quo[31]};
  assign take  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= take ? 24'(trial - {1'b0, dvs}) : trial[23:0];
      quo <= {quo[30:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == scw_pkg::DIV_CNT_W'(scw_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = (quo > MAX_Q) ? MAX_Q[LW-1:0] : quo[LW-1:0];

endmodule

// ===== rtl/scw_back.sv =====
// ----------------------------------------------------------------------------
// scw_back: path sequencer
// Run the cell count divides for a load and step the serpentine walk.
// ----------------------------------------------------------------------------
module scw_back #(
  parameter int MAX_CELLS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [23:0]                  diameter,
  input  scw_pkg::cmd_t                cmd_rd,
  input  logic                         cmd_empty,
  output logic                         cmd_pop,
  output logic                         div_start,
  output logic [31:0]                  div_dividend,
  input  logic                         div_done,
  input  logic [$clog2(MAX_CELLS)-1:0] div_q,
  output logic                         res_push,
  output scw_pkg::res_t                res_wr,
  input  logic                         res_full
);

  localparam int LW = $clog2(MAX_CELLS);
  localparam int CW = $clog2(MAX_CELLS + 1);
  localparam int PW = CW + 24;
  localparam int SW = ((PW > 32) ? PW : 32) + 2;

  scw_pkg::bk_state_t state, state_next;

  logic          path_active;
  logic [31:0]   width_span;
  logic [31:0]   height_span;
  logic [LW-1:0] last_column;
  logic [LW-1:0] last_row;
  logic [CW-1:0] row_counter;
  logic [CW-1:0] column_counter;
  logic [PW-1:0] col_dist;
  logic [PW-1:0] row_dist;
  logic          do_step;

  logic               last_c;
  logic               last_r;
  logic signed [SW-1:0] half_s;
  logic signed [SW-1:0] wspan_s;
  logic signed [SW-1:0] hspan_s;
  logic signed [SW-1:0] cd_s;
  logic signed [SW-1:0] rd_s;
  logic signed [SW-1:0] x_full;
  logic signed [SW-1:0] y_full;
  logic [CW+10:0]       row_ext;
  logic [CW+10:0]       col_ext;

  function automatic logic [31:0] sat32(input logic signed [SW-1:0] v);
    logic fits;
    fits = (v[SW-1:31] == '0) || (v[SW-1:31] == '1);
    if (fits) begin
      return v[31:0];
    end
    return v[SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  assign last_c = (column_counter == (CW'(last_column) + 1'b1));
  assign last_r = (row_counter == (CW'(last_row) + 1'b1));

  // Cell distances follow the present diameter, so a rewrite mid-path holds.
  assign col_dist = PW'(column_counter) * PW'(diameter);
  assign row_dist = PW'(row_counter) * PW'(diameter);

  assign half_s  = $signed(SW'(diameter[23:1]));
  assign wspan_s = $signed(SW'(width_span));
  assign hspan_s = $signed(SW'(height_span));
  assign cd_s    = $signed(SW'(col_dist));
  assign rd_s    = $signed(SW'(row_dist));

  // Odd rows run left to right, even rows right to left; clamp at the edges.
  always_comb begin
    if (!row_counter[0]) begin
      x_full = last_c ? half_s : wspan_s + half_s - cd_s;
    end else begin
      x_full = last_c ? wspan_s - half_s : cd_s - half_s;
    end
    y_full = last_r ? half_s - hspan_s : half_s - rd_s;
  end

  assign row_ext = {11'b0, row_counter};
  assign col_ext = {11'b0, column_counter};

  always_comb begin
    res_wr = '0;
    if (path_active) begin
      res_wr.point_x     = sat32(x_full);
      res_wr.point_y     = sat32(y_full);
      res_wr.row_number  = row_ext[10:0];
      res_wr.step_number = col_ext[10:0];
      res_wr.final_point = last_c && last_r;
      res_wr.point_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scw_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd_pop      = 1'b0;
    div_start    = 1'b0;
    div_dividend = height_span;
    res_push     = 1'b0;
    do_step      = 1'b0;
    unique case (state)
      scw_pkg::BK_IDLE: begin
        if (!cmd_empty) begin
          if (cmd_rd.op == scw_pkg::OP_LOAD) begin
            cmd_pop      = 1'b1;
            div_start    = 1'b1;
            div_dividend = cmd_rd.width_span;
            state_next   = scw_pkg::BK_DIV_W;
          end else if (!res_full) begin
            cmd_pop  = 1'b1;
            res_push = 1'b1;
            do_step  = path_active;
          end
        end
      end
      scw_pkg::BK_DIV_W: begin
        if (div_done) begin
          div_start  = 1'b1;
          state_next = scw_pkg::BK_DIV_H;
        end
      end
      scw_pkg::BK_DIV_H: begin
        if (div_done) begin
          state_next = scw_pkg::BK_EMIT;
        end
      end
      scw_pkg::BK_EMIT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          do_step    = 1'b1;
          state_next = scw_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = scw_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      path_active    <= 1'b0;
      width_span     <= '0;
      height_span    <= '0;
      last_column    <= '0;
      last_row       <= '0;
      row_counter    <= '0;
      column_counter <= '0;
    end else begin
      if (state == scw_pkg::BK_IDLE && div_start) begin
        width_span  <= cmd_rd.width_span;
        height_span <= cmd_rd.height_span;
        path_active <= 1'b0;
      end
      if (state == scw_pkg::BK_DIV_W && div_done) begin
        last_column <= div_q;
      end
      if (state == scw_pkg::BK_DIV_H && div_done) begin
        last_row       <= div_q;
        row_counter    <= CW'(1);
        column_counter <= CW'(1);
        path_active    <= 1'b1;
      end
      if (do_step) begin
        if (last_c && last_r) begin
          path_active <= 1'b0;
        end else if (last_c) begin
          column_counter <= CW'(1);
          row_counter    <= row_counter + 1'b1;
        end else begin
          column_counter <= column_counter + 1'b1;
        end
      end
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result written into a full queue");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (res_push && !res_wr.point_valid) |->
      (res_wr.point_x == 0 && res_wr.point_y == 0 && res_wr.row_number == 0 &&
       res_wr.step_number == 0 && !res_wr.final_point))
    else $error("invalid result carries non-zero fields");

  a_final_ends: assert property (@(posedge clk) disable iff (rst)
    (do_step && res_wr.final_point) |=> !path_active)
    else $error("path still active after its final point");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    path_active |-> (column_counter <= (CW'(last_column) + 1'b1) &&
                     row_counter <= (CW'(last_row) + 1'b1)))
    else $error("walk counter beyond the rectangle");

endmodule

// ===== rtl/serpentine_coverage_waypoints_core.sv =====
// ----------------------------------------------------------------------------
// serpentine_coverage_waypoints_core: boustrophedon coverage path generator
// Emits one Q16.16 waypoint per request over a rectangle, row by row.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through a queue-style port: a request is taken at a clock
//   edge with push high and full low. op 0 loads a rectangle (corners in
//   signed Q16.16) and yields its first waypoint; op 1 yields the next one.
//   Results leave through a second queue: while empty is low the oldest
//   waypoint sits on the result ports; pop high at a clock edge takes it.
//   Write the robot diameter through cfg_we / cfg_wdata while nothing is in
//   flight; it resets to 0.3 (19661 in Q16.16).
// Request handling:
//   A next request is answered from the back end's idle state, so a stream
//   of them runs at one waypoint per cycle while the result queue has room;
//   each passes the request queue and then the result queue. A load runs the
//   32-step bit-serial divider twice (columns then rows) before its waypoint
//   is written, and the back end takes no other request meanwhile.
// Reset and stalls:
//   Reset empties both queues and drops any path; a next request before a
//   load answers with point_valid low. When the receiver stalls, the result
//   queue fills, then the request queue, and full rises.
// ----------------------------------------------------------------------------
module serpentine_coverage_waypoints_core #(
  parameter int MAX_CELLS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic [23:0]        cfg_wdata,
  // request side
  input  logic               push,
  output logic               full,
  input  logic               op,
  input  logic signed [31:0] upper_left_x,
  input  logic signed [31:0] upper_left_y,
  input  logic signed [31:0] upper_right_x,
  input  logic signed [31:0] lower_left_y,
  // result side
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic [10:0]        row_number,
  output logic [10:0]        step_number,
  output logic               final_point,
  output logic               point_valid
);

  localparam int          LW             = $clog2(MAX_CELLS);
  localparam logic [23:0] DIAMETER_RESET = 24'd19661;

  logic [23:0]          robot_diameter;

  logic                 q_push;
  scw_pkg::cmd_t        q_wr;
  logic                 q_full;
  scw_pkg::cmd_t        q_rd;
  logic                 q_empty;
  logic                 q_pop;

  logic                 div_start;
  logic [31:0]          div_dividend;
  logic                 div_done;
  logic [LW-1:0]        div_q;

  logic                 res_push;
  scw_pkg::res_t        res_wr;
  logic                 res_full;
  scw_pkg::res_t        res_rd;

  // Hold the diameter; the user must rewrite it only while no request is in flight; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      robot_diameter <= DIAMETER_RESET;
    end else if (cfg_we) begin
      robot_diameter <= cfg_wdata;
    end
  end

  // Front end: take the request and fold the corners into spans.
  scw_front u_front (
    .push          (push),
    .full          (full),
    .op            (op),
    .upper_left_x  (upper_left_x),
    .upper_left_y  (upper_left_y),
    .upper_right_x (upper_right_x),
    .lower_left_y  (lower_left_y),
    .q_push        (q_push),
    .q_data        (q_wr),
    .q_full        (q_full)
  );

  // Request queue decouples intake from a back end busy dividing.
  scw_fifo #(
    .WIDTH ($bits(scw_pkg::cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  // Shared divider: columns first, then rows.
  scw_div #(
    .MAX_CELLS (MAX_CELLS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (robot_diameter),
    .done     (div_done),
    .quotient (div_q)
  );

  // Back end: sequence the walk and form each waypoint.
  scw_back #(
    .MAX_CELLS (MAX_CELLS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .diameter     (robot_diameter),
    .cmd_rd       (q_rd),
    .cmd_empty    (q_empty),
    .cmd_pop      (q_pop),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_done     (div_done),
    .div_q        (div_q),
    .res_push     (res_push),
    .res_wr       (res_wr),
    .res_full     (res_full)
  );

  // Result queue: the back end keeps running while the receiver stalls, until this queue is full.
  scw_fifo #(
    .WIDTH ($bits(scw_pkg::res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

  assign point_x     = res_rd.point_x;
  assign point_y     = res_rd.point_y;
  assign row_number  = res_rd.row_number;
  assign step_number = res_rd.step_number;
  assign final_point = res_rd.final_point;
  assign point_valid = res_rd.point_valid;

endmodule
